FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/nnis_pkg.sv
package nnis_pkg;

  localparam int MAX_ROW_PIXELS = 1024;
  localparam int MAX_COPIES     = 16;
  localparam int HEIGHT_LIMIT   = 1024;
  localparam int BURST          = 16;
  localparam int Q_ONE          = 256;
  localparam int REP_MAX        = MAX_COPIES - 1;

  localparam int PIX_W   = 24;
  localparam int DIM_W   = 11;
  localparam int SCALE_W = 12;
  localparam int COL_W   = $clog2(MAX_ROW_PIXELS);
  localparam int ROW_W   = $clog2(HEIGHT_LIMIT);
  localparam int OUT_W   = 14;
  localparam int REP_W   = 5;
  localparam int CNT_W   = $clog2(BURST) + 1;
  localparam int PROD_W  = DIM_W + SCALE_W;
  localparam int FRAC_W  = 8;
  localparam int DIV_W   = OUT_W + FRAC_W;
  localparam int STEP_W  = $clog2(DIV_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SCALE_W;
  localparam int TDATA_W    = ((PIX_W + REP_W + 7) / 8) * 8;
  localparam int TUSER_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_SCALE  = 2'd2
  } cfg_idx_t;

endpackage

FILE: rtl/nearest_neighbor_image_scaler.sv
// Channel  Ports                          Payload
// in       in_tvalid/in_tready            tdata: pixel_in; tuser: cmd
// out      out_tvalid/out_tready          tdata: pixel_out, rows_pending; tuser: flags;
//                                         tlast: last
// cfg      cfg_valid/cfg_ready            cfg_index, cfg_data
//
// Pixel word: states S_MW to S_DEC, then one result word per free cycle (1 to 16 words).
// Pull word: a 22-step restoring divider maps the replay column, then S_RD and S_PULL.
// A shared 11x12 multiplier forms output sizes and row/column bounds per word.
// rst_n clears state, counters, out_tvalid and sets config defaults; row store is not cleared.
// A full output register stalls the sequencer; the input is taken only when idle.
`include "assert_macros.svh"

module nearest_neighbor_image_scaler (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [nnis_pkg::PIX_W-1:0]       in_tdata,   // [23:0] pixel_in
  input  logic                             in_tuser,   // [0] cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [nnis_pkg::TDATA_W-1:0]     out_tdata,  // [23:0] pixel_out, [28:24] rows_pending
  output logic [nnis_pkg::TUSER_W-1:0]     out_tuser,  // [0] out_valid, [1] row_end, [2] frame_end
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nnis_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MW, S_MH, S_MA, S_MB, S_DEC, S_EMIT, S_DIV, S_RD, S_PULL
  } state_t;

  state_t               state_r;
  logic [DIM_W-1:0]     src_width_r, src_height_r;
  logic [SCALE_W-1:0]   scale_r;

  logic [COL_W-1:0]     src_col_r;
  logic [ROW_W-1:0]     src_row_r;
  logic [OUT_W-1:0]     out_col_r, out_row_r, replay_r;
  logic [REP_W-1:0]     repeats_r;

  logic                 cmd_r;
  logic [PIX_W-1:0]     pix_r;
  logic [OUT_W-1:0]     ow_r, oh_r;
  logic [PROD_W-1:0]    prod_r, a_r;
  logic [15:0]          jend_r;
  logic                 active_r, row_done_r, set_rep_r, do_px_r;
  logic [REP_W-1:0]     pend_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_W-1:0]     dq_r;
  logic [SCALE_W-1:0]   rem_r;
  logic [STEP_W-1:0]    step_r;

  logic [PIX_W-1:0]     row_mem [MAX_ROW_PIXELS];
  logic [PIX_W-1:0]     rd_data_r;
  logic                 wr_en, rd_en;
  logic [COL_W-1:0]     rd_addr;

  logic                 out_tvalid_r, out_tlast_r;
  logic [TDATA_W-1:0]   out_tdata_r;
  logic [TUSER_W-1:0]   out_tuser_r;
  logic                 out_free;

  logic [DIM_W-1:0]     w_eff, h_eff, mul_a;
  logic [SCALE_W-1:0]   s_eff;
  logic                 up;

  // decision terms
  logic                 act_cmp, active, row_done, set_rep, do_px;
  logic [15:0]          jend_nxt, hi_full, hi_cl, orow1, rep_raw;
  logic [REP_W-1:0]     rep_sat;

  // emit terms
  logic                 cond, cond_nx, em_last, em_re, em_fe;
  logic [15:0]          oc16;

  // divider step
  logic [SCALE_W:0]     trial;
  logic                 ge;

  // pull terms
  logic                 p_re, p_fe;
  logic [REP_W-1:0]     rep_dec, p_pend;

  // result load
  logic                 ld_en, ld_valid, ld_re, ld_fe, ld_last;
  logic [PIX_W-1:0]     ld_pix;
  logic [REP_W-1:0]     ld_pend;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= DIM_W'(640);
      src_height_r <= DIM_W'(480);
      scale_r      <= SCALE_W'(Q_ONE);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:  src_width_r  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: src_height_r <= cfg_data[DIM_W-1:0];
        CFG_SCALE:  scale_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (src_width_r == '0) w_eff = DIM_W'(1);
    else if (src_width_r > DIM_W'(MAX_ROW_PIXELS)) w_eff = DIM_W'(MAX_ROW_PIXELS);
    else w_eff = src_width_r;
    if (src_height_r == '0) h_eff = DIM_W'(1);
    else if (src_height_r > DIM_W'(HEIGHT_LIMIT)) h_eff = DIM_W'(HEIGHT_LIMIT);
    else h_eff = src_height_r;
    s_eff = (scale_r == '0) ? SCALE_W'(1) : scale_r;
    up    = s_eff > SCALE_W'(Q_ONE);
  end

  // shared multiplier operand
  always_comb begin
    case (state_r)
      S_MW:    mul_a = w_eff;
      S_MH:    mul_a = h_eff;
      S_MA:    mul_a = DIM_W'(src_row_r) + DIM_W'(up);
      S_MB:    mul_a = DIM_W'(src_col_r) + DIM_W'(up);
      default: mul_a = '0;
    endcase
  end

  // pixel word decision
  always_comb begin
    do_px    = !cmd_r && (repeats_r == '0);
    act_cmp  = up ? (a_r > {1'b0, out_row_r, 8'b0})
                  : (a_r[PROD_W-1:FRAC_W] == {1'b0, out_row_r});
    active   = (out_row_r < oh_r) && act_cmp;
    jend_nxt = up ? 16'((24'(prod_r) + 24'd255) >> FRAC_W)
                  : 16'(prod_r[PROD_W-1:FRAC_W]) + 16'd1;
    row_done = (DIM_W'(src_col_r) + DIM_W'(1)) >= w_eff;
    hi_full  = 16'((24'(a_r) + 24'd255) >> FRAC_W);
    hi_cl    = (hi_full > 16'(oh_r)) ? 16'(oh_r) : hi_full;
    orow1    = 16'(out_row_r) + 16'd1;
    rep_raw  = (hi_cl > orow1) ? hi_cl - orow1 : 16'd0;
    rep_sat  = (rep_raw > 16'(REP_MAX)) ? REP_W'(REP_MAX) : rep_raw[REP_W-1:0];
    set_rep  = row_done && active && up;
  end

  // burst emission
  always_comb begin
    oc16    = 16'(out_col_r);
    cond    = active_r && (oc16 < jend_r) && (out_col_r < ow_r)
              && (cnt_r < CNT_W'(BURST));
    cond_nx = active_r && (oc16 + 16'd1 < jend_r)
              && (15'(out_col_r) + 15'd1 < 15'(ow_r))
              && (cnt_r + CNT_W'(1) < CNT_W'(BURST));
    em_last = !cond || !cond_nx;
    em_re   = cond && (15'(out_col_r) + 15'd1 == 15'(ow_r));
    em_fe   = em_re && (15'(out_row_r) + 15'd1 == 15'(oh_r));
  end

  // divider step and replay read
  always_comb begin
    trial   = {rem_r, dq_r[DIV_W-1]};
    ge      = trial >= {1'b0, s_eff};
    rd_addr = (dq_r >= DIV_W'(w_eff)) ? COL_W'(w_eff - DIM_W'(1)) : dq_r[COL_W-1:0];
    rd_en   = (state_r == S_RD);
    wr_en   = (state_r == S_DEC) && do_px;
  end

  // replay pixel
  always_comb begin
    p_re    = (15'(replay_r) + 15'd1) >= 15'(ow_r);
    p_fe    = p_re && (15'(out_row_r) + 15'd1 == 15'(oh_r));
    rep_dec = repeats_r - REP_W'(1);
    p_pend  = p_re ? rep_dec : repeats_r;
  end

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    ld_en    = 1'b0;
    ld_valid = 1'b0;
    ld_pix   = '0;
    ld_re    = 1'b0;
    ld_fe    = 1'b0;
    ld_pend  = pend_r;
    ld_last  = 1'b1;
    if (state_r == S_EMIT) begin
      ld_en    = out_free;
      ld_valid = cond;
      ld_pix   = cond ? pix_r : '0;
      ld_re    = em_re;
      ld_fe    = em_fe;
      ld_last  = em_last;
    end else if (state_r == S_PULL) begin
      ld_en    = out_free;
      ld_valid = 1'b1;
      ld_pix   = rd_data_r;
      ld_re    = p_re;
      ld_fe    = p_fe;
      ld_pend  = p_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) row_mem[src_col_r] <= pix_r;
    if (rd_en) rd_data_r <= row_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      src_col_r    <= '0;
      src_row_r    <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      repeats_r    <= '0;
      replay_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(s_eff);

      if (ld_en) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= TDATA_W'({ld_pend, ld_pix});
        out_tuser_r  <= {ld_fe, ld_re, ld_valid};
        out_tlast_r  <= ld_last;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= in_tuser;
            pix_r   <= in_tdata;
            state_r <= S_MW;
          end
        end
        S_MW: state_r <= S_MH;
        S_MH: begin
          ow_r    <= prod_r[PROD_W-2:FRAC_W];
          state_r <= S_MA;
        end
        S_MA: begin
          oh_r    <= prod_r[PROD_W-2:FRAC_W];
          state_r <= S_MB;
        end
        S_MB: begin
          a_r     <= prod_r;
          state_r <= S_DEC;
        end
        S_DEC: begin
          do_px_r <= do_px;
          cnt_r   <= '0;
          if (do_px) begin
            active_r   <= active;
            jend_r     <= jend_nxt;
            row_done_r <= row_done;
            set_rep_r  <= set_rep;
            pend_r     <= set_rep ? rep_sat : repeats_r;
          end else begin
            active_r  <= 1'b0;
            set_rep_r <= 1'b0;
            pend_r    <= repeats_r;
          end
          if (cmd_r && (repeats_r != '0)) begin
            dq_r    <= {replay_r, {FRAC_W{1'b0}}};
            rem_r   <= '0;
            step_r  <= '0;
            state_r <= S_DIV;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (cond) cnt_r <= cnt_r + CNT_W'(1);
            if (em_last && do_px_r && row_done_r) out_col_r <= '0;
            else if (cond) out_col_r <= out_col_r + OUT_W'(1);
            if (em_last) begin
              state_r <= S_IDLE;
              if (do_px_r) begin
                if (row_done_r) begin
                  src_col_r <= '0;
                  if (set_rep_r) begin
                    repeats_r <= pend_r;
                    replay_r  <= '0;
                  end
                  if (DIM_W'(src_row_r) + DIM_W'(1) >= h_eff) begin
                    src_row_r <= '0;
                    if (pend_r == '0) out_row_r <= '0;
                    else if (active_r) out_row_r <= out_row_r + OUT_W'(1);
                  end else begin
                    src_row_r <= src_row_r + ROW_W'(1);
                    if (active_r) out_row_r <= out_row_r + OUT_W'(1);
                  end
                end else begin
                  src_col_r <= src_col_r + COL_W'(1);
                end
              end
            end
          end
        end
        S_DIV: begin
          rem_r  <= ge ? SCALE_W'(trial - {1'b0, s_eff}) : trial[SCALE_W-1:0];
          dq_r   <= {dq_r[DIV_W-2:0], ge};
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(DIV_W - 1)) state_r <= S_RD;
        end
        S_RD: state_r <= S_PULL;
        S_PULL: begin
          if (out_free) begin
            state_r <= S_IDLE;
            if (p_re) begin
              replay_r  <= '0;
              repeats_r <= rep_dec;
              if ((rep_dec == '0) && (src_row_r == '0)) out_row_r <= '0;
              else out_row_r <= out_row_r + OUT_W'(1);
            end else begin
              replay_r <= replay_r + OUT_W'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  `ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "word taken while busy")
  `ASSERT_IMP(a_empty_is_last, out_tvalid_r && !out_tuser_r[0], out_tlast_r, "empty not final")
  `ASSERT_IMP(a_frame_ends_row, out_tvalid_r && out_tuser_r[2], out_tuser_r[1], "frame end off row end")
  `ASSERT_IMP(a_repeat_bound, 1'b1, repeats_r <= REP_W'(REP_MAX), "repeat count overflow")

endmodule
